// ===== rtl/core/hrav_pkg.sv =====
// ----------------------------------------------------------------------------
// hrav_pkg
// Shared types and constants for the heart rate interval averager.
// ----------------------------------------------------------------------------
`default_nettype none

package hrav_pkg;

   // Shared divider width: covers 60000 / interval and history sum / count.
   localparam int DIV_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int AVG_DEPTH_DEF = 4;

   localparam int IR_W = 18;
   localparam int TIME_W = 32;
   localparam int INTERVAL_W = 16;
   localparam int RATE_W = 8;

   localparam logic [DIV_W-1:0] MS_PER_MINUTE = 16'd60000;

   // Configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ENABLED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINGER_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE_BPM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE_BPM = 3'd5;

   localparam logic RST_SENSOR_ENABLED = 1'b1;
   localparam logic [IR_W-1:0] RST_FINGER_THRESHOLD = 18'd50000;
   localparam logic [INTERVAL_W-1:0] RST_MIN_INTERVAL_MS = 16'd350;
   localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL_MS = 16'd1400;
   localparam logic [RATE_W-1:0] RST_MIN_RATE_BPM = 8'd48;
   localparam logic [RATE_W-1:0] RST_MAX_RATE_BPM = 8'd160;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RATE_DIV,
      ST_SUM,
      ST_MEAN_DIV,
      ST_FINISH
   } hrav_state_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } hrav_div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIV_W-1:0] quotient;
   } hrav_div_sts_type;

   typedef struct packed {
      logic push;
      logic clear;
   } hrav_hist_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/hrav_req_if.sv =====
// ----------------------------------------------------------------------------
// hrav_req_if
// Request channel: one poll with infrared sample, beat flag and time.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrav_req_if;
   logic valid;
   logic ready;
   logic [hrav_pkg::IR_W-1:0] ir_sample;
   logic beat_seen;
   logic [hrav_pkg::TIME_W-1:0] time_ms;

   modport source (output valid, output ir_sample, output beat_seen, output time_ms,
                   input ready);
   modport sink (input valid, input ir_sample, input beat_seen, input time_ms,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrav_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hrav_rsp_if
// Response channel: finger status, averaged rate and beat acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrav_rsp_if;
   logic valid;
   logic ready;
   logic finger_detected;
   logic [hrav_pkg::RATE_W-1:0] heart_rate_bpm;
   logic beat_accepted;

   modport source (output valid, output finger_detected, output heart_rate_bpm,
                   output beat_accepted, input ready);
   modport sink (input valid, input finger_detected, input heart_rate_bpm,
                 input beat_accepted, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrav_csr_if.sv =====
// ----------------------------------------------------------------------------
// hrav_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrav_csr_if;
   logic valid;
   logic ready;
   logic [hrav_pkg::CSR_IDX_W-1:0] index;
   logic [hrav_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/heart_rate_interval_averager.sv =====
// ----------------------------------------------------------------------------
// heart_rate_interval_averager
// Beat interval to heart rate, averaged over a short history.
// ----------------------------------------------------------------------------
// Sequence: a request that evaluates no beat goes from evaluation straight to
//   the response register; a beat in the interval window makes one rate pass
//   through the 16-step divider and ends there if it fails the rate bounds;
//   a beat entering history then sums the history and makes a mean pass. Each
//   path can stall on the response. One request at a time: the next request
//   is taken no earlier than the cycle after the response register is loaded.
// Reset: synchronous; config registers take their documented defaults, the
//   state goes idle and the history fill count is cleared. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_interval_averager #(
   parameter int AVG_DEPTH = hrav_pkg::AVG_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   hrav_req_if.sink  req_port,
   hrav_rsp_if.source rsp_port,
   hrav_csr_if.sink  csr_port
);

   localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int CNT_W = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W = $clog2(AVG_DEPTH * 255 + 1);
   localparam int W = hrav_pkg::DIV_W;
   localparam int TW = hrav_pkg::TIME_W;
   localparam int RW = hrav_pkg::RATE_W;

   // configuration
   logic sensor_enabled_ff;
   logic [hrav_pkg::IR_W-1:0] finger_threshold_ff;
   logic [hrav_pkg::INTERVAL_W-1:0] min_interval_ff;
   logic [hrav_pkg::INTERVAL_W-1:0] max_interval_ff;
   logic [RW-1:0] min_rate_ff;
   logic [RW-1:0] max_rate_ff;

   // latched request
   logic [hrav_pkg::IR_W-1:0] ir_ff;
   logic beat_ff;
   logic [TW-1:0] time_ff;

   // state
   hrav_pkg::hrav_state_type state_ff, state_in;
   logic [TW-1:0] last_beat_ff;
   logic finger_ff;
   logic [RW-1:0] rate_ff;
   logic accepted_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SLOT_W-1:0] idx_ff;

   // response register
   logic rsp_valid_ff;
   logic rsp_finger_ff;
   logic [RW-1:0] rsp_rate_ff;
   logic rsp_accepted_ff;

   hrav_pkg::hrav_div_req_type div_req;
   hrav_pkg::hrav_div_sts_type div_sts;
   hrav_pkg::hrav_hist_ctrl_type hist_ctrl;
   logic [RW-1:0] hist_rd_data;
   logic [CNT_W-1:0] fill_count;

   logic req_take;
   logic rsp_load;
   logic finger_now;
   logic [TW-1:0] delta;
   logic in_window;
   logic rate_ok;
   logic [SUM_W-1:0] sum_in;
   logic sum_last;

   always_comb begin
      finger_now = ir_ff > finger_threshold_ff;
      delta = time_ff - last_beat_ff;
      in_window = (delta > {16'd0, min_interval_ff}) && (delta < {16'd0, max_interval_ff});
      rate_ok = (div_sts.quotient >= {8'd0, min_rate_ff})
             && (div_sts.quotient <= {8'd0, max_rate_ff});
      sum_in = sum_ff + SUM_W'(hist_rd_data);
      sum_last = ((CNT_W'(idx_ff) + 1'b1) == fill_count);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hrav_pkg::ST_IDLE: begin
            if (req_port.valid) state_in = hrav_pkg::ST_EVAL;
         end
         hrav_pkg::ST_EVAL: begin
            if (sensor_enabled_ff && finger_now && beat_ff && in_window) begin
               state_in = hrav_pkg::ST_RATE_DIV;
            end else begin
               state_in = hrav_pkg::ST_FINISH;
            end
         end
         hrav_pkg::ST_RATE_DIV: begin
            if (div_sts.done) begin
               state_in = rate_ok ? hrav_pkg::ST_SUM : hrav_pkg::ST_FINISH;
            end
         end
         hrav_pkg::ST_SUM: begin
            if (sum_last) state_in = hrav_pkg::ST_MEAN_DIV;
         end
         hrav_pkg::ST_MEAN_DIV: begin
            if (div_sts.done) state_in = hrav_pkg::ST_FINISH;
         end
         hrav_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) state_in = hrav_pkg::ST_IDLE;
         end
         default: state_in = hrav_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_take = 1'b0;
      rsp_load = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = hrav_pkg::MS_PER_MINUTE;
      div_req.divisor = delta[W-1:0];
      hist_ctrl.push = 1'b0;
      hist_ctrl.clear = 1'b0;
      unique case (state_ff)
         hrav_pkg::ST_IDLE: begin
            req_take = req_port.valid;
         end
         hrav_pkg::ST_EVAL: begin
            hist_ctrl.clear = sensor_enabled_ff && !finger_now;
            div_req.start = sensor_enabled_ff && finger_now && beat_ff && in_window;
         end
         hrav_pkg::ST_RATE_DIV: begin
            hist_ctrl.push = div_sts.done && rate_ok;
         end
         hrav_pkg::ST_SUM: begin
            div_req.start = sum_last;
            div_req.dividend = W'(sum_in);
            div_req.divisor = W'(fill_count);
         end
         hrav_pkg::ST_MEAN_DIV: begin
         end
         hrav_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_port.ready;
         end
         default: begin
         end
      endcase
   end

   assign req_port.ready = (state_ff == hrav_pkg::ST_IDLE);
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrav_pkg::ST_IDLE;
         sensor_enabled_ff <= hrav_pkg::RST_SENSOR_ENABLED;
         finger_threshold_ff <= hrav_pkg::RST_FINGER_THRESHOLD;
         min_interval_ff <= hrav_pkg::RST_MIN_INTERVAL_MS;
         max_interval_ff <= hrav_pkg::RST_MAX_INTERVAL_MS;
         min_rate_ff <= hrav_pkg::RST_MIN_RATE_BPM;
         max_rate_ff <= hrav_pkg::RST_MAX_RATE_BPM;
         last_beat_ff <= '0;
         finger_ff <= 1'b0;
         rate_ff <= '0;
         accepted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_port.valid) begin
            unique case (csr_port.index)
               hrav_pkg::CSR_SENSOR_ENABLED: sensor_enabled_ff <= csr_port.data[0];
               hrav_pkg::CSR_FINGER_THRESHOLD: finger_threshold_ff <= csr_port.data;
               hrav_pkg::CSR_MIN_INTERVAL_MS: min_interval_ff <= csr_port.data[15:0];
               hrav_pkg::CSR_MAX_INTERVAL_MS: max_interval_ff <= csr_port.data[15:0];
               hrav_pkg::CSR_MIN_RATE_BPM: min_rate_ff <= csr_port.data[7:0];
               hrav_pkg::CSR_MAX_RATE_BPM: max_rate_ff <= csr_port.data[7:0];
               default: begin
               end
            endcase
         end
         if (state_ff == hrav_pkg::ST_EVAL) begin
            accepted_ff <= 1'b0;
            if (sensor_enabled_ff) begin
               finger_ff <= finger_now;
               if (!finger_now) begin
                  rate_ff <= '0;
               end else if (beat_ff) begin
                  last_beat_ff <= time_ff;
               end
            end
         end
         if (state_ff == hrav_pkg::ST_MEAN_DIV && div_sts.done) begin
            rate_ff <= div_sts.quotient[RW-1:0];
            accepted_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         ir_ff <= req_port.ir_sample;
         beat_ff <= req_port.beat_seen;
         time_ff <= req_port.time_ms;
      end
      if (hist_ctrl.push) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else if (state_ff == hrav_pkg::ST_SUM) begin
         sum_ff <= sum_in;
         idx_ff <= idx_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_finger_ff <= finger_ff;
         rsp_rate_ff <= rate_ff;
         rsp_accepted_ff <= accepted_ff;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.finger_detected = rsp_finger_ff;
   assign rsp_port.heart_rate_bpm = rsp_rate_ff;
   assign rsp_port.beat_accepted = rsp_accepted_ff;

   hrav_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   hrav_history #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_history (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (hist_ctrl),
      .wr_data    (div_sts.quotient[RW-1:0]),
      .rd_idx     (idx_ff),
      .rd_data    (hist_rd_data),
      .fill_count (fill_count)
   );

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_sum_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == hrav_pkg::ST_SUM |-> fill_count != '0)
      else $error("history sum with empty fill");

   a_accept_needs_finger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_accepted_ff |-> rsp_finger_ff)
      else $error("beat accepted without finger");

   a_no_finger_zero_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_finger_ff |-> rsp_rate_ff == '0)
      else $error("nonzero rate without finger");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == hrav_pkg::ST_EVAL)
      else $error("request taken but not evaluated");

endmodule

`default_nettype wire

// ===== rtl/core/hrav_divider.sv =====
// ----------------------------------------------------------------------------
// hrav_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// rate and mean computations. Divisor is never zero at this block's use.
// ----------------------------------------------------------------------------
`default_nettype none

module hrav_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hrav_pkg::hrav_div_req_type div_req,
   output      hrav_pkg::hrav_div_sts_type div_sts
);

   localparam int W = hrav_pkg::DIV_W;
   localparam int CW = hrav_pkg::DIV_CNT_W;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] dsr_ff, dsr_in;

   logic [W:0] rem_shift;
   logic [W:0] diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[W-1]};
      diff = rem_shift - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         dsr_in = div_req.divisor;
      end else if (busy_ff) begin
         if (diff[W]) begin
            rem_in = rem_shift[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hrav_history.sv =====
// ----------------------------------------------------------------------------
// hrav_history
// Rate history: circular write slot, saturating fill count, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hrav_history #(
   parameter int AVG_DEPTH = hrav_pkg::AVG_DEPTH_DEF,
   localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1,
   localparam int CNT_W = $clog2(AVG_DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire hrav_pkg::hrav_hist_ctrl_type ctrl,
   input  wire logic [hrav_pkg::RATE_W-1:0]  wr_data,
   input  wire logic [SLOT_W-1:0]            rd_idx,
   output      logic [hrav_pkg::RATE_W-1:0]  rd_data,
   output      logic [CNT_W-1:0]             fill_count
);

   logic [hrav_pkg::RATE_W-1:0] hist_ff [AVG_DEPTH];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (ctrl.clear) begin
         slot_in = '0;
         fill_in = '0;
      end else if (ctrl.push) begin
         slot_in = (slot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         if (fill_ff != CNT_W'(AVG_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
      end
      if (ctrl.push && !ctrl.clear) begin
         hist_ff[slot_ff] <= wr_data;
      end
   end

   assign rd_data = hist_ff[rd_idx];
   assign fill_count = fill_ff;

endmodule

`default_nettype wire
